[rtl/trie_pkg.sv]
// ----------------------------------------------------------------------------
// Trie package
// Shared sizes, operation and status codes, and controller state type for the
// prefix trie unit.
// ----------------------------------------------------------------------------
package trie_pkg;

    // Node storage and alphabet size.
    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int SYM_W         = $clog2(ALPHABET_SIZE);
    localparam int ROW_W         = ALPHABET_SIZE * NODE_W;

    // Stream field widths.
    localparam int OP_W          = 2;
    localparam int LETTER_W      = 5;
    localparam int STATUS_W      = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 8;

    // Operation codes; the unused code is handled as a search.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DELETED   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FLAG
    } t_state;

endpackage

[rtl/trie_insert_search_delete_unit.sv]
// A result is registered in the flag stage, which follows the walk step of the last
// letter of a word. Letters are accepted only in the idle state: each is taken with
// its child row read, then walked with an optional write-back; a last letter also takes
// the flag stage, which waits while the output register holds an unaccepted result.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all NODE_COUNT (1024)
// rows of both memories while the input is held not ready.
// ----------------------------------------------------------------------------
// Trie insert/search/delete unit
// Walks a prefix trie one letter per transfer, allocating nodes on insert and
// setting, testing or clearing the end-of-word flag on the last letter.
// ----------------------------------------------------------------------------
module trie_insert_search_delete_unit
    import trie_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [1:0] op, [6:2] letter, [7] zero
    input  logic                   i_s_tlast,   // last letter of the word
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [2:0] status, [7:3] zero
);

    // Controller registers.
    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_clr_addr, n_clr_addr;
    logic [NODE_W-1:0]   r_used, n_used;
    logic [NODE_W-1:0]   r_cur_node, n_cur_node;
    logic                r_broken, n_broken;
    logic                r_over, n_over;
    t_op                 r_op, n_op;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;

    // Memory ports.
    logic                chd_we;
    logic [NODE_W-1:0]   chd_waddr;
    logic [ROW_W-1:0]    chd_wdata;
    logic [NODE_W-1:0]   chd_raddr;
    logic [ROW_W-1:0]    chd_rdata;
    logic                flg_we;
    logic [NODE_W-1:0]   flg_waddr;
    logic                flg_wdata;
    logic [NODE_W-1:0]   flg_raddr;
    logic                flg_rdata;

    // Decode helpers.
    logic                in_xfer;
    logic                out_free;
    logic                halted;
    logic [NODE_W-1:0]   child;
    logic [NODE_W-1:0]   new_id;
    logic [OP_W-1:0]     in_op;
    logic [LETTER_W-1:0] in_letter;
    logic [LETTER_W-1:0] in_sym;

    // Child table: one row of child ids per node.
    trie_ram #(
        .DEPTH(NODE_COUNT),
        .WIDTH(ROW_W)
    ) u_chd_ram (
        .i_clk  (i_clk),
        .i_we   (chd_we),
        .i_waddr(chd_waddr),
        .i_wdata(chd_wdata),
        .i_raddr(chd_raddr),
        .o_rdata(chd_rdata)
    );

    // End-of-word flags: one bit per node.
    trie_ram #(
        .DEPTH(NODE_COUNT),
        .WIDTH(1)
    ) u_flg_ram (
        .i_clk  (i_clk),
        .i_we   (flg_we),
        .i_waddr(flg_waddr),
        .i_wdata(flg_wdata),
        .i_raddr(flg_raddr),
        .o_rdata(flg_rdata)
    );

    // Handshake and field decode.
    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign in_op      = i_s_tdata[OP_W-1:0];
    assign in_letter  = i_s_tdata[OP_W+LETTER_W-1:OP_W];
    assign in_sym     = (in_letter >= LETTER_W'(ALPHABET_SIZE)) ?
                        (in_letter - LETTER_W'(ALPHABET_SIZE)) : in_letter;
    assign halted     = r_broken || r_over;
    assign child      = chd_rdata[int'(r_sym)*NODE_W +: NODE_W];
    assign new_id     = r_used + 1'b1;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = r_last ? S_FLAG : S_IDLE;
            end
            S_FLAG: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath, memory controls and result register next values.
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_used      = r_used;
        n_cur_node  = r_cur_node;
        n_broken    = r_broken;
        n_over      = r_over;
        n_op        = r_op;
        n_sym       = r_sym;
        n_last      = r_last;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_tready;
        chd_we      = 1'b0;
        chd_waddr   = r_cur_node;
        chd_wdata   = chd_rdata;
        chd_raddr   = r_cur_node;
        flg_we      = 1'b0;
        flg_waddr   = r_cur_node;
        flg_wdata   = 1'b0;
        flg_raddr   = r_cur_node;

        unique case (r_state)
            S_CLEAR: begin
                // Zero one row of each memory per cycle.
                chd_we     = 1'b1;
                chd_waddr  = r_clr_addr;
                chd_wdata  = '0;
                flg_we     = 1'b1;
                flg_waddr  = r_clr_addr;
                flg_wdata  = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                // Capture the letter; the current row read is already issued.
                if (in_xfer) begin
                    unique case (in_op)
                        OP_INSERT: n_op = OP_INSERT;
                        OP_DELETE: n_op = OP_DELETE;
                        default:   n_op = OP_SEARCH;
                    endcase
                    n_sym  = SYM_W'(in_sym);
                    n_last = i_s_tlast;
                end
            end
            S_EXEC: begin
                // Walk one step, allocating a node on an insert miss.
                if (!halted) begin
                    if (child != '0) begin
                        n_cur_node = child;
                    end else if (r_op == OP_INSERT) begin
                        if (r_used != NODE_W'(NODE_COUNT - 1)) begin
                            n_used     = new_id;
                            n_cur_node = new_id;
                            chd_we     = 1'b1;
                            chd_wdata[int'(r_sym)*NODE_W +: NODE_W] = new_id;
                        end else begin
                            n_over = 1'b1;
                        end
                    end else begin
                        n_broken = 1'b1;
                    end
                end
                flg_raddr = n_cur_node;
            end
            S_FLAG: begin
                // Apply the word action and post the status.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    case (r_op)
                        OP_INSERT: begin
                            n_status  = halted ? ST_FULL : ST_INSERTED;
                            flg_we    = !halted;
                            flg_wdata = 1'b1;
                        end
                        OP_DELETE: begin
                            n_status  = ST_DELETED;
                            flg_we    = !halted;
                            flg_wdata = 1'b0;
                        end
                        default: begin
                            n_status = (!halted && flg_rdata) ? ST_FOUND : ST_NOT_FOUND;
                        end
                    endcase
                    n_cur_node = '0;
                    n_broken   = 1'b0;
                    n_over     = 1'b0;
                end
            end
            default: begin
                n_clr_addr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_cur_node  <= '0;
            r_broken    <= 1'b0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_used      <= n_used;
            r_cur_node  <= n_cur_node;
            r_broken    <= n_broken;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_status);

    // The walk never reaches a node that has not been allocated.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_node <= r_used)
        else $error("current node beyond allocated nodes");

    // Allocation count never shrinks once the clearing pass is done.
    a_used_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_used >= $past(r_used)))
        else $error("node allocation count decreased");

    // A new result only comes from the flag stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_FLAG))
        else $error("result posted outside the flag stage");

    // No result is pending while the memories are being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_m_tvalid)
        else $error("result valid during clearing pass");

endmodule

[rtl/trie_ram.sv]
// ----------------------------------------------------------------------------
// Trie RAM
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered. No reset on the contents.
// ----------------------------------------------------------------------------
module trie_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
